// ===== hdl/apt_pkg.sv =====
package apt_pkg;

  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y        = 3'd4;

  localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

  localparam int ANGLE_W = 20;
  localparam int Z_W     = 36;
  localparam int XY_W    = 34;

  localparam logic signed [Z_W-1:0]  Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [Z_W-1:0]  Q30_PI      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] Q30_GAIN    = 34'sd652032874;

  // rotated value range is +-(2^32 - 1)
  localparam int ROT_W = 33;
  localparam longint ROT_LIMIT = 64'sd4294967295;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic                   kind;
    logic                   ovf;
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
  } rot_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/affine_point_transform_2d.sv =====
// 4 register stages: an input passes v1, rot_valid, v3, then out_valid
// throughput: one item per cycle, a held output stalls every full stage behind it
// an angle write steps the cordic through wrap, fold, iterate, round and done;
// input and config transfers wait until it finishes
// reset (sync, active high): empty pipeline, translate 0, scale 1.0, cos 1, sin 0
module affine_point_transform_2d
  import apt_pkg::*;
#(
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int COS_W = FRAC_BITS + 2;

  logic signed [31:0] translate_x;
  logic signed [31:0] translate_y;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;

  logic                    trig_ready;
  logic signed [COS_W-1:0] cos_val;
  logic signed [COS_W-1:0] sin_val;
  logic                    cfg_write;
  logic                    start;
  logic                    take;
  logic                    rot_ready;
  logic                    scl_ready;
  logic                    rot_valid;
  rot_t                    rot_item;

  assign cfg_ready = trig_ready;
  assign cfg_write = cfg_valid && cfg_ready;
  assign start     = cfg_write && (cfg_index == REG_ROTATION_ANGLE);
  assign in_stall  = !rot_ready || !trig_ready;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      translate_x <= '0;
      translate_y <= '0;
      scale_x     <= SCALE_RESET;
      scale_y     <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRANSLATE_X: translate_x <= cfg_data;
        REG_TRANSLATE_Y: translate_y <= cfg_data;
        REG_SCALE_X:     scale_x     <= cfg_data;
        REG_SCALE_Y:     scale_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  apt_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .angle      (cfg_data[ANGLE_W-1:0]),
    .trig_ready (trig_ready),
    .cos_val    (cos_val),
    .sin_val    (sin_val)
  );

  apt_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_item    (in_data),
    .cos_val    (cos_val),
    .sin_val    (sin_val),
    .ready      (rot_ready),
    .down_ready (scl_ready),
    .rot_valid  (rot_valid),
    .rot_item   (rot_item)
  );

  apt_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .rot_valid   (rot_valid),
    .rot_item    (rot_item),
    .ready       (scl_ready),
    .scale_x     (scale_x),
    .scale_y     (scale_y),
    .translate_x (translate_x),
    .translate_y (translate_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    !trig_ready |-> !take && !cfg_write)
    else $error("transfer during trig update");

endmodule

// ===== hdl/apt_cordic.sv =====
module apt_cordic
  import apt_pkg::*;
#(
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [ANGLE_W-1:0]   angle,
  output logic                        trig_ready,
  output logic signed [FRAC_BITS+1:0] cos_val,
  output logic signed [FRAC_BITS+1:0] sin_val
);

  localparam int COS_W  = FRAC_BITS + 2;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int RND_SH = 30 - FRAC_BITS;
  localparam logic signed [XY_W-1:0] HALF_LSB = 34'sd1 <<< (29 - FRAC_BITS);
  localparam logic signed [XY_W-1:0] ONE_Q    = 34'sd1 <<< FRAC_BITS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRAP  = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_ITER  = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]              state;
  logic signed [Z_W-1:0]   z;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic                    neg;
  logic [STEP_W-1:0]       step;

  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [Z_W-1:0]   angle_step;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [XY_W-1:0]  xc;
  logic signed [XY_W-1:0]  yc;

  assign trig_ready = (state == ST_IDLE);

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign angle_step = atan_q30(5'(step));

  // sign fix for the folded half plane, then clamp to +-1.0
  always_comb begin
    xs = neg ? -x : x;
    ys = neg ? -y : y;
    xc = xs;
    yc = ys;
    if (xs > ONE_Q) xc = ONE_Q;
    else if (xs < -ONE_Q) xc = -ONE_Q;
    if (ys > ONE_Q) yc = ONE_Q;
    else if (ys < -ONE_Q) yc = -ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cos_val <= COS_W'(ONE_Q);
      sin_val <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            z     <= {{2{angle[ANGLE_W-1]}}, angle, 14'b0};
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (z > Q30_PI) z <= z - Q30_TWO_PI;
          else if (z < -Q30_PI) z <= z + Q30_TWO_PI;
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (z > Q30_HALF_PI) begin
            z   <= z - Q30_PI;
            neg <= 1'b1;
          end else if (z < -Q30_HALF_PI) begin
            z   <= z + Q30_PI;
            neg <= 1'b1;
          end else begin
            neg <= 1'b0;
          end
          x     <= Q30_GAIN;
          y     <= '0;
          step  <= '0;
          state <= ST_ITER;
        end
        ST_ITER: begin
          if (!z[Z_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - angle_step;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + angle_step;
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) state <= ST_ROUND;
        end
        ST_ROUND: begin
          x     <= (x + HALF_LSB) >>> RND_SH;
          y     <= (y + HALF_LSB) >>> RND_SH;
          state <= ST_DONE;
        end
        ST_DONE: begin
          cos_val <= xc[COS_W-1:0];
          sin_val <= yc[COS_W-1:0];
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    (cos_val <= COS_W'(ONE_Q)) && (cos_val >= -COS_W'(ONE_Q)))
    else $error("cosine outside unit range");

  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    (sin_val <= COS_W'(ONE_Q)) && (sin_val >= -COS_W'(ONE_Q)))
    else $error("sine outside unit range");

  a_trig_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DONE) |=> $stable(cos_val) && $stable(sin_val))
    else $error("trig values changed outside final step");

endmodule

// ===== hdl/apt_rotate.sv =====
module apt_rotate
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  in_t                         in_item,
  input  logic signed [FRAC_BITS+1:0] cos_val,
  input  logic signed [FRAC_BITS+1:0] sin_val,
  output logic                        ready,
  input  logic                        down_ready,
  output logic                        rot_valid,
  output rot_t                        rot_item
);

  localparam int COS_W  = FRAC_BITS + 2;
  localparam int PROD_W = COS_W + 32;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] LIM = SUM_W'(ROT_LIMIT);

  logic                     v1;
  logic                     kind1;
  logic signed [PROD_W-1:0] p_cx;
  logic signed [PROD_W-1:0] p_sy;
  logic signed [PROD_W-1:0] p_sx;
  logic signed [PROD_W-1:0] p_cy;

  logic en1;
  logic en2;

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sh_x;
  logic signed [SUM_W-1:0] sh_y;
  logic signed [SUM_W-1:0] cl_x;
  logic signed [SUM_W-1:0] cl_y;
  logic                    ovf_rot;

  assign en2   = !rot_valid || down_ready;
  assign en1   = !v1 || en2;
  assign ready = en1;

  always_comb begin
    sum_x   = SUM_W'(p_cx) - SUM_W'(p_sy);
    sum_y   = SUM_W'(p_sx) + SUM_W'(p_cy);
    sh_x    = sum_x >>> FRAC_BITS;
    sh_y    = sum_y >>> FRAC_BITS;
    cl_x    = sh_x;
    cl_y    = sh_y;
    ovf_rot = 1'b0;
    if (sh_x > LIM) begin
      cl_x    = LIM;
      ovf_rot = 1'b1;
    end else if (sh_x < -LIM) begin
      cl_x    = -LIM;
      ovf_rot = 1'b1;
    end
    if (sh_y > LIM) begin
      cl_y    = LIM;
      ovf_rot = 1'b1;
    end else if (sh_y < -LIM) begin
      cl_y    = -LIM;
      ovf_rot = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      rot_valid <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) rot_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1 <= in_item.kind;
      p_cx  <= cos_val * in_item.x_in;
      p_sy  <= sin_val * in_item.y_in;
      p_sx  <= sin_val * in_item.x_in;
      p_cy  <= cos_val * in_item.y_in;
    end
    if (en2) begin
      rot_item.kind <= kind1;
      rot_item.ovf  <= ovf_rot;
      rot_item.rx   <= cl_x[ROT_W-1:0];
      rot_item.ry   <= cl_y[ROT_W-1:0];
    end
  end

  a_rot_hold: assert property (@(posedge clk) disable iff (rst)
    rot_valid && !down_ready |=> rot_valid && $stable(rot_item))
    else $error("rotated item lost while held");

endmodule

// ===== hdl/apt_scale.sv =====
module apt_scale
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rot_valid,
  input  rot_t               rot_item,
  output logic               ready,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] translate_x,
  input  logic signed [31:0] translate_y,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  localparam int MUL_W = 32 + ROT_W;
  localparam int ACC_W = MUL_W + 1;
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] MINV = ACC_W'(-64'sd2147483648);

  logic                    v3;
  logic                    kind3;
  logic                    ovf3;
  logic signed [MUL_W-1:0] m_x;
  logic signed [MUL_W-1:0] m_y;

  logic en3;
  logic en4;

  logic signed [MUL_W-1:0] sh_x;
  logic signed [MUL_W-1:0] sh_y;
  logic signed [31:0]      tx;
  logic signed [31:0]      ty;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [31:0]      res_x;
  logic signed [31:0]      res_y;
  logic                    ovf_out;

  assign en4   = !out_valid || !out_stall;
  assign en3   = !v3 || en4;
  assign ready = en3;

  always_comb begin
    sh_x    = m_x >>> FRAC_BITS;
    sh_y    = m_y >>> FRAC_BITS;
    tx      = kind3 ? 32'sd0 : translate_x;
    ty      = kind3 ? 32'sd0 : translate_y;
    acc_x   = ACC_W'(sh_x) + ACC_W'(tx);
    acc_y   = ACC_W'(sh_y) + ACC_W'(ty);
    res_x   = acc_x[31:0];
    res_y   = acc_y[31:0];
    ovf_out = ovf3;
    if (acc_x > MAXV) begin
      res_x   = 32'sh7fffffff;
      ovf_out = 1'b1;
    end else if (acc_x < MINV) begin
      res_x   = 32'sh80000000;
      ovf_out = 1'b1;
    end
    if (acc_y > MAXV) begin
      res_y   = 32'sh7fffffff;
      ovf_out = 1'b1;
    end else if (acc_y < MINV) begin
      res_y   = 32'sh80000000;
      ovf_out = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) v3 <= rot_valid;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      kind3 <= rot_item.kind;
      ovf3  <= rot_item.ovf;
      m_x   <= scale_x * rot_item.rx;
      m_y   <= scale_y * rot_item.ry;
    end
    if (en4) begin
      out_data.x_out    <= res_x;
      out_data.y_out    <= res_y;
      out_data.overflow <= ovf_out;
    end
  end

endmodule
